### rtl/window_sum_nearest_target_assert.svh
// Assertion macros for the window sum nearest target block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef WINDOW_SUM_NEAREST_TARGET_ASSERT_SVH
`define WINDOW_SUM_NEAREST_TARGET_ASSERT_SVH

// Check that cond_a implies cond_b in the same cycle.
`define WSNT_ASSERT_SAME(label, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond_a) |-> (cond_b)) else $error(msg);

// Check that cond_a implies cond_b in the next cycle.
`define WSNT_ASSERT_NEXT(label, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond_a) |=> (cond_b)) else $error(msg);

`endif

### rtl/wsnt_pkg.sv
// Shared widths, limits and register indexes for the window sum nearest target block.
// No dependencies.
package wsnt_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TARGET_W   = 24;
	localparam int WLEN_W     = 7;
	localparam int START_W    = 16;
	localparam int DIST_W     = 24;
	localparam int CFG_DATA_W = 24;
	localparam int REG_IDX_W  = 1;

	localparam int MAX_WINDOW = 64;
	localparam int MAX_STREAM = 65536;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_VALUE  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

### rtl/window_sum_nearest_target.sv
// Top level of the window sum nearest target block: delay chain, running sum and scoring.
// Depends on wsnt_pkg, wsnt_cell and window_sum_nearest_target_assert.svh.
//
// Channel  Direction  Handshake          Payload
// cfg      in         wr_en              wr_index, wr_data
// in       in         in_valid/in_stall  sample, last
// out      out        out_valid/out_stall best_start, best_distance, too_short
//
// One sample is taken every cycle unless the input is stalled; the running sum, the
// distance and the best window update form a three-stage path: the sum is registered
// in s1, the distance in s2, and the result in the output register. The input
// stalls only while a finished result still waits at the output and the next last sample has reached the final stage.
// Reset restores window length 1, target 0 and an empty stream; no clearing pass.
module window_sum_nearest_target #(
	parameter int MAX_WINDOW = wsnt_pkg::MAX_WINDOW,
	parameter int MAX_STREAM = wsnt_pkg::MAX_STREAM
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [wsnt_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [wsnt_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [wsnt_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [wsnt_pkg::START_W-1:0]         best_start,
	output logic [wsnt_pkg::DIST_W-1:0]          best_distance,
	output logic                                 too_short
);

	`include "window_sum_nearest_target_assert.svh"

	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int CNT_W  = $clog2(MAX_STREAM + 1);
	localparam int SUM_W  = wsnt_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int DIFF_W = ((SUM_W > wsnt_pkg::TARGET_W) ? SUM_W : wsnt_pkg::TARGET_W) + 1;
	localparam int DW     = wsnt_pkg::DIST_W;
	localparam int SW     = wsnt_pkg::START_W;

	// Configuration and stream state
	logic [wsnt_pkg::WLEN_W-1:0]          wl_q;
	logic signed [wsnt_pkg::TARGET_W-1:0] tgt_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]                     count_q;
	logic [DW-1:0]                        low_dist_q;
	logic [SW-1:0]                        low_start_q;

	// Pipeline
	logic                    v_s1, last_s1, score_s1, first_s1, short_s1;
	logic [SW-1:0]           start_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic                    v_s2, last_s2, score_s2, first_s2, short_s2;
	logic [SW-1:0]           start_s2;
	logic signed [DIFF_W-1:0] diff_s2;

	// Output register
	logic          out_valid_q;
	logic [SW-1:0] out_start_q;
	logic [DW-1:0] out_dist_q;
	logic          out_short_q;

	// Combinational
	logic                    adv, accept_in, take_out, processing, full_before, take;
	logic [WIN_W-1:0]        win_len;
	logic [CNT_W-1:0]        count_next, count_after;
	logic signed [SUM_W-1:0] sum_next, sum_after;
	logic [31:0]             start_full;
	logic [DIFF_W-1:0]       mag;
	logic [DW-1:0]           near_dist;
	wsnt_pkg::sample_t       chain [MAX_WINDOW];
	wsnt_pkg::sample_t       old_sample;

	// Hold the pipeline only when a last transaction would overwrite a waiting result
	assign adv       = !(v_s2 && last_s2 && out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign accept_in = in_valid && !in_stall;
	assign take_out  = out_valid_q && !out_stall;

	// Clamp the window length to 1..MAX_WINDOW
	always_comb begin
		if (wl_q == '0) begin
			win_len = WIN_W'(1);
		end else if (int'(wl_q) > MAX_WINDOW) begin
			win_len = WIN_W'(MAX_WINDOW);
		end else begin
			win_len = WIN_W'(wl_q);
		end
	end

	// Delay chain: the last cell holds the sample leaving the window
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		wsnt_cell #(
			.IDX        (i),
			.MAX_WINDOW (MAX_WINDOW),
			.WIN_W      (WIN_W)
		) u_cell (
			.clk      (clk),
			.shift_en (accept_in && processing),
			.win_len  (win_len),
			.sample   (sample),
			.prev     ((i == 0) ? sample : chain[(i == 0) ? 0 : i - 1]),
			.value    (chain[i])
		);
	end

	assign old_sample = chain[MAX_WINDOW-1];

	// Running sum and window bookkeeping for the incoming sample
	always_comb begin
		processing  = int'(count_q) < MAX_STREAM;
		full_before = int'(count_q) >= int'(win_len);
		count_next  = count_q + CNT_W'(1);
		sum_next    = sum_q - (full_before ? SUM_W'(old_sample) : SUM_W'(0)) + SUM_W'(sample);
		count_after = processing ? count_next : count_q;
		sum_after   = processing ? sum_next : sum_q;
		start_full  = 32'(count_after) - 32'(win_len);
	end

	// Distance of the window sum from the target, saturated
	always_comb begin
		mag       = diff_s2[DIFF_W-1] ? DIFF_W'(-diff_s2) : DIFF_W'(diff_s2);
		near_dist = (|mag[DIFF_W-1:DW]) ? {DW{1'b1}} : mag[DW-1:0];
		take      = score_s2 && (first_s2 || (near_dist < low_dist_q));
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= wsnt_pkg::WLEN_W'(1);
			tgt_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			low_dist_q  <= '1;
			low_start_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Advance the running sum; drop the stream on its last sample
			if (accept_in) begin
				if (last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else if (processing) begin
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end

			if (adv) begin
				v_s1 <= accept_in;
				v_s2 <= v_s1;
			end

			// Track the nearest window; clear it when the stream ends
			if (adv && v_s2) begin
				if (last_s2) begin
					low_dist_q  <= '1;
					low_start_q <= '0;
				end else if (take) begin
					low_dist_q  <= near_dist;
					low_start_q <= start_s2;
				end
			end

			if (adv && v_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (take_out) begin
				out_valid_q <= 1'b0;
			end

			// Register writes; a new window length also clears the stream
			if (wr_en) begin
				unique case (wr_index)
					wsnt_pkg::REG_WINDOW_LENGTH: begin
						wl_q        <= wr_data[wsnt_pkg::WLEN_W-1:0];
						sum_q       <= '0;
						count_q     <= '0;
						low_dist_q  <= '1;
						low_start_q <= '0;
					end
					wsnt_pkg::REG_TARGET_VALUE: begin
						tgt_q <= wr_data[wsnt_pkg::TARGET_W-1:0];
					end
				endcase
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1  <= last;
			score_s1 <= processing && (int'(count_after) >= int'(win_len));
			first_s1 <= (start_full == 32'd0);
			short_s1 <= int'(count_after) < int'(win_len);
			start_s1 <= SW'(start_full);
			sum_s1   <= sum_after;

			last_s2  <= last_s1;
			score_s2 <= score_s1;
			first_s2 <= first_s1;
			short_s2 <= short_s1;
			start_s2 <= start_s1;
			diff_s2  <= DIFF_W'(sum_s1) - DIFF_W'(tgt_q);
		end
	end

	// Load the result when the last transaction leaves the final stage
	always_ff @(posedge clk) begin
		if (adv && v_s2 && last_s2) begin
			if (short_s2) begin
				out_start_q <= '0;
				out_dist_q  <= '0;
				out_short_q <= 1'b1;
			end else begin
				out_start_q <= take ? start_s2 : low_start_q;
				out_dist_q  <= take ? near_dist : low_dist_q;
				out_short_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign best_start    = out_start_q;
	assign best_distance = out_dist_q;
	assign too_short     = out_short_q;

	`WSNT_ASSERT_SAME(a_stall_cause, in_stall, v_s2 && last_s2 && out_valid_q && out_stall,
		"input stalled without a blocked result")
	`WSNT_ASSERT_NEXT(a_best_cleared, adv && v_s2 && last_s2,
		low_dist_q == {DW{1'b1}} && low_start_q == '0, "best window not cleared after result")
	`WSNT_ASSERT_SAME(a_short_zero, out_valid_q && out_short_q,
		out_start_q == '0 && out_dist_q == '0, "short stream result carries data")
	`WSNT_ASSERT_SAME(a_count_limit, 1'b1, int'(count_q) <= MAX_STREAM,
		"sample count beyond stream limit")

endmodule

### rtl/wsnt_cell.sv
// One cell of the sample delay chain: holds one sample and passes it on.
// Depends on wsnt_pkg.
module wsnt_cell #(
	parameter int IDX        = 0,
	parameter int MAX_WINDOW = wsnt_pkg::MAX_WINDOW,
	parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
	input  logic             clk,
	input  logic             shift_en,
	input  logic [WIN_W-1:0] win_len,
	input  wsnt_pkg::sample_t sample,
	input  wsnt_pkg::sample_t prev,
	output wsnt_pkg::sample_t value
);

	wsnt_pkg::sample_t value_q;
	logic              inject;

	// Enter the new sample here when this cell sits window length from the end
	assign inject = (IDX == (MAX_WINDOW - int'(win_len)));

	// Advance one place per transaction
	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= inject ? sample : prev;
		end
	end

	assign value = value_q;

endmodule

### tb/window_best_checker.sv
`timescale 1ns / 100ps
// Checker for window_sum_nearest_target: watches the register port and both channels.
// Predicts the nearest-window result of each stream and compares it at the output.
// Depends on wsnt_pkg.
module window_best_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [wsnt_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [wsnt_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  wsnt_pkg::sample_t               sample,
	input  logic                            last,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [wsnt_pkg::START_W-1:0]    best_start,
	input  logic [wsnt_pkg::DIST_W-1:0]     best_distance,
	input  logic                            too_short,
	output int                              error_count,
	output int                              pending_count
);

	typedef struct packed {
		logic [wsnt_pkg::START_W-1:0] start;
		logic [wsnt_pkg::DIST_W-1:0]  distance;
		logic                         is_short;
	} window_best_t;

	localparam logic [wsnt_pkg::DIST_W-1:0] DIST_SAT = '1;

	window_best_t best_q[$];

	// Predicted block state
	logic [wsnt_pkg::WLEN_W-1:0]          win_len;
	logic signed [wsnt_pkg::TARGET_W-1:0] target;
	wsnt_pkg::sample_t                    ring_mem [wsnt_pkg::MAX_WINDOW];
	longint                               run_sum;
	int                                   seen;
	int                                   ring_pos;
	logic [wsnt_pkg::DIST_W-1:0]          low_dist;
	logic [wsnt_pkg::START_W-1:0]         low_start;

	task automatic restart_stream();
		run_sum   = 0;
		seen      = 0;
		ring_pos  = 0;
		low_dist  = DIST_SAT;
		low_start = '0;
	endtask

	// Advance the window by one sample; queue the stream's best window on the last mark
	task automatic score_sample(input wsnt_pkg::sample_t value, input logic mark);
		int                          span;
		int                          old_slot;
		longint                      diff;
		logic [wsnt_pkg::DIST_W-1:0] cand_dist;
		window_best_t                res;
		span = (win_len == 0) ? 1 :
			((win_len > wsnt_pkg::MAX_WINDOW) ? wsnt_pkg::MAX_WINDOW : int'(win_len));
		if (seen < wsnt_pkg::MAX_STREAM) begin
			if (seen >= span) begin
				old_slot = (ring_pos + wsnt_pkg::MAX_WINDOW - span) % wsnt_pkg::MAX_WINDOW;
				run_sum -= ring_mem[old_slot];
			end
			run_sum += value;
			ring_mem[ring_pos] = value;
			ring_pos = (ring_pos + 1) % wsnt_pkg::MAX_WINDOW;
			seen++;
			if (seen >= span) begin
				diff = run_sum - target;
				if (diff < 0)
					diff = -diff;
				cand_dist = (diff > longint'(DIST_SAT)) ? DIST_SAT : wsnt_pkg::DIST_W'(diff);
				// first full window always wins; later ones only when strictly nearer
				if (seen == span || cand_dist < low_dist) begin
					low_dist  = cand_dist;
					low_start = wsnt_pkg::START_W'(seen - span);
				end
			end
		end
		if (mark) begin
			if (seen < span) begin
				res.start    = '0;
				res.distance = '0;
				res.is_short = 1'b1;
			end else begin
				res.start    = low_start;
				res.distance = low_dist;
				res.is_short = 1'b0;
			end
			best_q.push_back(res);
			restart_stream();
		end
	endtask

	task automatic note_mismatch(input string why, input window_best_t want);
		error_count++;
		if (error_count <= 10)
			$display("%0t checker: %s: want %0d/%0d/%0b, got %0d/%0d/%0b (start/dist/short)",
				$time, why, want.start, want.distance, want.is_short,
				best_start, best_distance, too_short);
	endtask

	// Track register writes, predict on each input transaction, check each output one
	always @(posedge clk or negedge arst_n) begin
		window_best_t want;
		if (!arst_n) begin
			win_len     = 1;
			target      = '0;
			error_count = 0;
			best_q.delete();
			restart_stream();
		end else begin
			if (out_valid && !out_stall) begin
				if (best_q.size() == 0) begin
					note_mismatch("result with none expected", '0);
				end else begin
					want = best_q.pop_front();
					if (best_start !== want.start || best_distance !== want.distance ||
							too_short !== want.is_short)
						note_mismatch("result mismatch", want);
				end
			end
			if (wr_en) begin
				if (wr_index == wsnt_pkg::REG_WINDOW_LENGTH) begin
					win_len = wr_data[wsnt_pkg::WLEN_W-1:0];
					restart_stream();
				end else if (wr_index == wsnt_pkg::REG_TARGET_VALUE) begin
					target = wr_data[wsnt_pkg::TARGET_W-1:0];
				end
			end
			if (in_valid && !in_stall)
				score_sample(sample, last);
		end
		pending_count = best_q.size();
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the window_sum_nearest_target testbench: clock, reset, stimulus and verdict.
// Depends on wsnt_pkg, the block itself and window_best_checker.
module testbench;

	localparam int LATENCY      = 2;
	localparam int DRAIN_CYCLES = LATENCY + 3;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            wr_en = 1'b0;
	logic [wsnt_pkg::REG_IDX_W-1:0]  wr_index = wsnt_pkg::REG_WINDOW_LENGTH;
	logic [wsnt_pkg::CFG_DATA_W-1:0] wr_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	wsnt_pkg::sample_t               sample = '0;
	logic                            last = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [wsnt_pkg::START_W-1:0]    best_start;
	logic [wsnt_pkg::DIST_W-1:0]     best_distance;
	logic                            too_short;

	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	int cur_len = 1;
	bit calm = 1'b0;

	window_sum_nearest_target u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_start   (best_start),
		.best_distance(best_distance),
		.too_short    (too_short)
	);

	window_best_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.best_start   (best_start),
		.best_distance(best_distance),
		.too_short    (too_short),
		.error_count  (errors),
		.pending_count(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the output about one cycle in five, except in the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 20);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Offer one sample transaction, with an occasional gap before it, and hold until taken
	task automatic push_sample(input wsnt_pkg::sample_t value, input logic mark);
		int  gap;
		bit  held;
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			gap = $urandom_range(3, 1);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		last     <= mark;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
		sent++;
	endtask

	// Drop valid, wait for every expected result, then let the pipeline settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wsnt_pkg::REG_IDX_W-1:0] idx,
			input logic [wsnt_pkg::CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// Reprogram window length and/or target once the block is idle
	task automatic set_regs(input bit do_len, input logic [wsnt_pkg::WLEN_W-1:0] len,
			input bit do_tgt, input logic [wsnt_pkg::TARGET_W-1:0] tgt);
		wait_drained();
		if (do_len) begin
			write_reg(wsnt_pkg::REG_WINDOW_LENGTH, {17'($urandom), len});
			cur_len = (len == 0) ? 1 :
				((len > wsnt_pkg::MAX_WINDOW) ? wsnt_pkg::MAX_WINDOW : int'(len));
		end
		if (do_tgt)
			write_reg(wsnt_pkg::REG_TARGET_VALUE, tgt);
		wr_en <= 1'b0;
	endtask

	function automatic wsnt_pkg::sample_t pick_sample(input int mode);
		case (mode)
			0: return wsnt_pkg::sample_t'($urandom);
			1: return wsnt_pkg::sample_t'(int'($urandom_range(6)) - 3);
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return wsnt_pkg::sample_t'(int'($urandom_range(400)) - 200);
		endcase
	endfunction

	function automatic logic [wsnt_pkg::TARGET_W-1:0] pick_target(input int span);
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'(int'($urandom_range(400)) - 200);
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'(span * (int'($urandom_range(200)) - 100));
		endcase
	endfunction

	function automatic logic [wsnt_pkg::WLEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 7'($urandom);
		if (r < 14)
			return $urandom_range(1) ? 7'd64 : 7'd0;
		return 7'($urandom_range(16, 1));
	endfunction

	initial begin
		int len;
		int split;
		int mode;
		int calm_from;
		int stop_at;
		bit quiet;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset defaults, single-sample stream
		push_sample(16'sh0000, 1'b1);
		// Zero length acts as one; most negative target, extreme samples
		set_regs(1'b1, 7'd0, 1'b1, 24'h800000);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b1);
		// Length above the maximum clamps; stream too short; largest target
		set_regs(1'b1, 7'd127, 1'b1, 24'h7FFFFF);
		push_sample(16'sh0001, 1'b0);
		push_sample(16'sh0002, 1'b0);
		push_sample(16'shFFFF, 1'b1);
		// Tied distances: the earlier window wins
		set_regs(1'b1, 7'd3, 1'b1, 24'h000000);
		push_sample(16'sh0005, 1'b0);
		push_sample(-16'sh0005, 1'b0);
		push_sample(16'sh0000, 1'b0);
		push_sample(16'sh0001, 1'b0);
		push_sample(16'shFFFF, 1'b1);
		// Target rewritten in the middle of a stream keeps earlier scores
		set_regs(1'b1, 7'd2, 1'b0, '0);
		push_sample(16'sh000A, 1'b0);
		push_sample(16'sh000A, 1'b0);
		set_regs(1'b0, '0, 1'b1, 24'd40);
		push_sample(16'sh001E, 1'b1);
		// Length rewritten in the middle of a stream restarts it
		push_sample(16'sh0001, 1'b0);
		push_sample(16'sh0002, 1'b0);
		set_regs(1'b1, 7'd1, 1'b0, '0);
		push_sample(16'sh0007, 1'b1);
		// Just above the maximum length, one sample
		set_regs(1'b1, 7'd65, 1'b0, '0);
		push_sample(16'shFFFF, 1'b1);

		// Random streams with random content and occasional reprogramming
		stop_at   = sent + RANDOM_ITEMS;
		calm_from = sent + $urandom_range(800, 200);
		while (sent < stop_at) begin
			quiet = (sent >= calm_from && sent < calm_from + 300);
			calm <= quiet;
			if (!quiet && $urandom_range(99) < 30)
				set_regs($urandom_range(1), pick_length(), $urandom_range(1),
					pick_target(cur_len));
			mode = $urandom_range(3);
			len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2 * cur_len + 4, 1);
			split = (!quiet && len > 1 && $urandom_range(9) == 0) ?
				$urandom_range(len - 1, 1) : 0;
			for (int i = 0; i < len; i++) begin
				if (split != 0 && i == split) begin
					if ($urandom_range(1))
						set_regs(1'b1, pick_length(), 1'b0, '0);
					else
						set_regs(1'b0, '0, 1'b1, pick_target(cur_len));
				end
				push_sample(pick_sample(mode), i == len - 1);
			end
		end
		calm <= 1'b0;

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
